@@ sv/amxi_pkg.sv @@
// ============================================================================
// amxi_pkg: shared types and helpers for the affine matrix inverse
// Fixed-point entry types, item records and the signed 32x32 multiply.
// ============================================================================
package amxi_pkg;

    localparam int FIX_W   = 32;            // Q-format entry width
    localparam int ADJ_W   = 64;            // cofactor width (differences wrap)
    localparam int DET_W   = 98;            // exact determinant, signed
    localparam int QUO_W   = 32;            // quotient bits resolved by the divider
    localparam int DIV_LAT = QUO_W + 3;     // register stages in one divider lane

    typedef logic signed [FIX_W-1:0] fix_t;
    typedef logic signed [ADJ_W-1:0] adj_t;
    typedef logic signed [DET_W-1:0] det_t;

    typedef struct packed {
        fix_t a00;
        fix_t a10;
        fix_t a20;
        fix_t a01;
        fix_t a11;
        fix_t a21;
        fix_t a02;
        fix_t a12;
        fix_t a22;
        fix_t shift_x;
        fix_t shift_y;
        fix_t shift_z;
    } mat_t;

    typedef struct packed {
        fix_t inv00;
        fix_t inv10;
        fix_t inv20;
        fix_t inv01;
        fix_t inv11;
        fix_t inv21;
        fix_t inv02;
        fix_t inv12;
        fix_t inv22;
        fix_t inv_shift_x;
        fix_t inv_shift_y;
        fix_t inv_shift_z;
    } inv_t;

    // cofactors indexed row*3+col, translation indexed by axis
    typedef struct packed {
        logic [8:0][ADJ_W-1:0] adj;
        det_t                  det;
        logic [2:0][FIX_W-1:0] t;
    } cof_t;

    // rounded linear part plus what the translation stage needs
    typedef struct packed {
        logic [8:0][FIX_W-1:0] q;
        logic [2:0][FIX_W-1:0] t;
        logic                  zero;
    } lin_t;

    function automatic adj_t mul_fix(fix_t x, fix_t y);
        adj_t xe;
        adj_t ye;
        xe = adj_t'(x);
        ye = adj_t'(y);
        return xe * ye;
    endfunction

endpackage

@@ sv/amxi_if.sv @@
// ============================================================================
// amxi_if: valid/ready channels of the affine matrix inverse
// One interface for the input matrix, one for the inverse.
// ============================================================================
interface amxi_mat_if;
    import amxi_pkg::*;

    logic valid;
    logic ready;
    mat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface amxi_inv_if;
    import amxi_pkg::*;

    logic valid;
    logic ready;
    inv_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/amxi_cof.sv @@
// ============================================================================
// amxi_cof: cofactor and determinant pipeline
// Five stages: products, cofactors, split det products, terms, det sum.
// ============================================================================
module amxi_cof (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  amxi_pkg::mat_t mat,
    output logic           out_valid,
    output amxi_pkg::cof_t cof
);
    import amxi_pkg::*;

    localparam int NSTG = 5;

    function automatic int nxt(int i);
        return (i == 2) ? 0 : i + 1;
    endfunction

    fix_t [2:0][2:0]        a;          // a[row][col]
    logic [8:0][ADJ_W-1:0]  pp_next;
    logic [8:0][ADJ_W-1:0]  ps_next;

    logic [8:0][ADJ_W-1:0]  pp_reg;
    logic [8:0][ADJ_W-1:0]  ps_reg;
    fix_t [2:0][2:0]        a1_reg;
    logic [2:0][FIX_W-1:0]  t1_reg;
    logic [8:0][ADJ_W-1:0]  adj2_reg;
    fix_t [2:0]             row2_reg;
    logic [2:0][FIX_W-1:0]  t2_reg;
    logic [2:0][ADJ_W-1:0]  hi3_reg;
    logic [2:0][ADJ_W:0]    lo3_reg;
    logic [8:0][ADJ_W-1:0]  adj3_reg;
    logic [2:0][FIX_W-1:0]  t3_reg;
    logic [2:0][DET_W-1:0]  term4_reg;
    logic [8:0][ADJ_W-1:0]  adj4_reg;
    logic [2:0][FIX_W-1:0]  t4_reg;
    cof_t                   cof_reg;
    logic [NSTG-1:0]        vld_reg;

    assign a[0][0] = mat.a00;
    assign a[0][1] = mat.a01;
    assign a[0][2] = mat.a02;
    assign a[1][0] = mat.a10;
    assign a[1][1] = mat.a11;
    assign a[1][2] = mat.a12;
    assign a[2][0] = mat.a20;
    assign a[2][1] = mat.a21;
    assign a[2][2] = mat.a22;

    // adj[r][c] = a[c1][r1]*a[c2][r2] - a[c1][r2]*a[c2][r1]
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pp_next[r*3+c] = mul_fix(a[nxt(c)][nxt(r)], a[nxt(nxt(c))][nxt(nxt(r))]);
                ps_next[r*3+c] = mul_fix(a[nxt(c)][nxt(nxt(r))], a[nxt(nxt(c))][nxt(r)]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_reg <= pp_next;
            ps_reg <= ps_next;
            a1_reg <= a;
            t1_reg <= {mat.shift_z, mat.shift_y, mat.shift_x};

            for (int k = 0; k < 9; k++)
            begin
                adj2_reg[k] <= pp_reg[k] - ps_reg[k];
            end
            row2_reg <= a1_reg[0];
            t2_reg   <= t1_reg;

            // adj * a split into signed high half and unsigned low half
            for (int i = 0; i < 3; i++)
            begin
                hi3_reg[i] <= mul_fix(fix_t'(adj2_reg[i*3][ADJ_W-1:FIX_W]), row2_reg[i]);
                lo3_reg[i] <= $signed({1'b0, adj2_reg[i*3][FIX_W-1:0]})
                              * $signed(row2_reg[i]);
            end
            adj3_reg <= adj2_reg;
            t3_reg   <= t2_reg;

            for (int i = 0; i < 3; i++)
            begin
                term4_reg[i] <= (DET_W'($signed(hi3_reg[i])) <<< FIX_W)
                                + DET_W'($signed(lo3_reg[i]));
            end
            adj4_reg <= adj3_reg;
            t4_reg   <= t3_reg;

            cof_reg.det <= term4_reg[0] + term4_reg[1] + term4_reg[2];
            cof_reg.adj <= adj4_reg;
            cof_reg.t   <= t4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign cof       = cof_reg;

endmodule

@@ sv/amxi_div.sv @@
// ============================================================================
// amxi_div: one rounding divider lane
// Rounded |adj| * 2^(2F) / |det| as 32 restoring steps, then saturation.
// ============================================================================
module amxi_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       adv,
    input  logic [amxi_pkg::ADJ_W-1:0] cm,
    input  logic [amxi_pkg::DET_W-1:0] dmag,
    input  logic                       neg,
    output amxi_pkg::fix_t             q
);
    import amxi_pkg::*;

    localparam int DW  = DET_W + 1;                       // divisor 2*|det|
    localparam int SHW = ADJ_W + 2 * FRAC_BITS + 1;
    localparam int NW  = ((SHW > DET_W) ? SHW : DET_W) + 1;
    localparam int HW  = NW - QUO_W;
    localparam int CW  = (HW > DW) ? HW : DW;

    logic [NW-1:0]    n_reg;
    logic [DW-1:0]    d0_reg;
    logic             neg0_reg;
    logic [CW-1:0]    nhi_x;
    logic             ovf_next;

    logic [DW-1:0]    rem_reg [QUO_W+1];
    logic [QUO_W-1:0] nlo_reg [QUO_W+1];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];
    logic [DW-1:0]    d_reg   [QUO_W+1];
    logic             ovf_reg [QUO_W+1];
    logic             neg_reg [QUO_W+1];

    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] mag;
    fix_t             q_reg;

    // quotient >= 2^32 exactly when the high part already reaches the divisor
    assign nhi_x    = CW'(n_reg[NW-1:QUO_W]);
    assign ovf_next = nhi_x >= CW'(d0_reg);

    assign lim = neg_reg[QUO_W] ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
    assign mag = (ovf_reg[QUO_W] || (quo_reg[QUO_W] > lim)) ? lim : quo_reg[QUO_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // numerator carries the half-divisor rounding term
            n_reg    <= (NW'(cm) << (2 * FRAC_BITS + 1)) + NW'(dmag);
            d0_reg   <= {dmag, 1'b0};
            neg0_reg <= neg;

            rem_reg[0] <= ovf_next ? '0 : nhi_x[DW-1:0];
            nlo_reg[0] <= n_reg[QUO_W-1:0];
            quo_reg[0] <= '0;
            d_reg[0]   <= d0_reg;
            ovf_reg[0] <= ovf_next;
            neg_reg[0] <= neg0_reg;

            for (int j = 0; j < QUO_W; j++)
            begin
                if ({rem_reg[j], nlo_reg[j][QUO_W-1]} >= {1'b0, d_reg[j]})
                begin
                    rem_reg[j+1] <= DW'({rem_reg[j], nlo_reg[j][QUO_W-1]} - {1'b0, d_reg[j]});
                    quo_reg[j+1] <= {quo_reg[j][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j+1] <= {rem_reg[j][DW-2:0], nlo_reg[j][QUO_W-1]};
                    quo_reg[j+1] <= {quo_reg[j][QUO_W-2:0], 1'b0};
                end
                nlo_reg[j+1] <= {nlo_reg[j][QUO_W-2:0], 1'b0};
                d_reg[j+1]   <= d_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end

            q_reg <= neg_reg[QUO_W] ? fix_t'(-mag) : fix_t'(mag);
        end
    end

    assign q = q_reg;

endmodule

@@ sv/amxi_xlat.sv @@
// ============================================================================
// amxi_xlat: inverse translation and final assembly
// Three stages: products, negated row sums, round and saturate.
// ============================================================================
module amxi_xlat #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  amxi_pkg::lin_t lin,
    output logic           out_valid,
    output amxi_pkg::inv_t inv
);
    import amxi_pkg::*;

    localparam int SW    = 2 * FIX_W + 3;
    localparam fix_t ONE = fix_t'(1) <<< FRAC_BITS;

    logic [8:0][ADJ_W-1:0] prod_reg;
    lin_t                  lin1_reg;
    logic [2:0][SW-1:0]    sum_reg;
    lin_t                  lin2_reg;
    fix_t [2:0]            sh_next;
    inv_t                  inv_reg;
    logic [2:0]            vld_reg;

    always_comb
    begin
        logic          sneg;
        logic [SW-1:0] m;
        logic [SW-1:0] rnd;
        logic [SW-1:0] lim;
        logic [SW-1:0] mm;
        for (int r = 0; r < 3; r++)
        begin
            sneg = sum_reg[r][SW-1];
            m    = sneg ? -sum_reg[r] : sum_reg[r];
            rnd  = (m + (SW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            lim  = sneg ? (SW'(1) << (FIX_W - 1)) : ((SW'(1) << (FIX_W - 1)) - SW'(1));
            mm   = (rnd > lim) ? lim : rnd;
            sh_next[r] = sneg ? fix_t'(-mm[FIX_W-1:0]) : fix_t'(mm[FIX_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r*3+c] <= mul_fix(fix_t'(lin.q[r*3+c]), fix_t'(lin.t[c]));
                end
            end
            lin1_reg <= lin;

            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= -(SW'($signed(prod_reg[r*3])) + SW'($signed(prod_reg[r*3+1]))
                               + SW'($signed(prod_reg[r*3+2])));
            end
            lin2_reg <= lin1_reg;

            // singular input gives the identity
            if (lin2_reg.zero)
            begin
                inv_reg.inv00       <= ONE;
                inv_reg.inv01       <= '0;
                inv_reg.inv02       <= '0;
                inv_reg.inv10       <= '0;
                inv_reg.inv11       <= ONE;
                inv_reg.inv12       <= '0;
                inv_reg.inv20       <= '0;
                inv_reg.inv21       <= '0;
                inv_reg.inv22       <= ONE;
                inv_reg.inv_shift_x <= '0;
                inv_reg.inv_shift_y <= '0;
                inv_reg.inv_shift_z <= '0;
            end
            else
            begin
                inv_reg.inv00       <= fix_t'(lin2_reg.q[0]);
                inv_reg.inv01       <= fix_t'(lin2_reg.q[1]);
                inv_reg.inv02       <= fix_t'(lin2_reg.q[2]);
                inv_reg.inv10       <= fix_t'(lin2_reg.q[3]);
                inv_reg.inv11       <= fix_t'(lin2_reg.q[4]);
                inv_reg.inv12       <= fix_t'(lin2_reg.q[5]);
                inv_reg.inv20       <= fix_t'(lin2_reg.q[6]);
                inv_reg.inv21       <= fix_t'(lin2_reg.q[7]);
                inv_reg.inv22       <= fix_t'(lin2_reg.q[8]);
                inv_reg.inv_shift_x <= sh_next[0];
                inv_reg.inv_shift_y <= sh_next[1];
                inv_reg.inv_shift_z <= sh_next[2];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    assign out_valid = vld_reg[2];
    assign inv       = inv_reg;

endmodule

@@ sv/affine_matrix_inverse.sv @@
// ============================================================================
// affine_matrix_inverse: pipelined inverse of a 3x4 affine transform
// Cofactors, exact determinant, nine rounding divider lanes, translation.
// ============================================================================
// Usage:
//   matrix  (sink)   : one transform per transfer, twelve Q entries.
//   inverse (source) : one inverse per transfer, in the same order.
//   The accepting edge loads the first of 45 register stages:
//   cofactors/determinant, sign split, the divider lanes (32 restoring
//   quotient steps), translation, output register.
//   Throughput is one transform per cycle while the skid entry is empty;
//   all stages before the output register share one advance enable.
//   The output register plus one skid entry decouple the two sides: while
//   the receiver stalls, the pipeline keeps running until a finished
//   result has to wait in the skid entry, then matrix.ready drops and all
//   stages hold. Nothing is dropped or repeated.
//   A singular linear part returns the identity with zero translation.
//   Reset clears all valid bits; the datapath registers are not reset and
//   the block needs no warm-up after reset.
// ============================================================================
module affine_matrix_inverse #(
    parameter int FRAC_BITS = 16
) (
    input logic              clk,
    input logic              rst_n,
    amxi_mat_if.sink         matrix,
    amxi_inv_if.source       inverse
);
    import amxi_pkg::*;

    typedef struct packed {
        logic [2:0][FIX_W-1:0] t;
        logic                  zero;
    } side_t;

    logic                  adv;

    logic                  cof_valid;
    cof_t                  cof;

    // sign split stage
    logic [8:0][ADJ_W-1:0] cm_reg;
    logic [8:0]            neg_reg;
    logic [DET_W-1:0]      dmag_reg;
    side_t                 prep_side_reg;
    logic                  prep_v_reg;
    logic                  dneg;

    // side band that runs alongside the divider lanes
    side_t                 sb_reg   [DIV_LAT];
    logic [DIV_LAT-1:0]    sb_v_reg;

    fix_t [8:0]            q;
    lin_t                  lin;

    logic                  x_valid;
    inv_t                  x_inv;

    logic                  out_v_reg;
    inv_t                  out_reg;
    logic                  skid_v_reg;
    inv_t                  skid_reg;

    // the whole pipeline advances unless a result is parked in the skid entry
    assign adv          = !skid_v_reg;
    assign matrix.ready = adv;

    amxi_cof u_cof (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (matrix.valid),
        .mat       (matrix.data),
        .out_valid (cof_valid),
        .cof       (cof)
    );

    assign dneg = cof.det[DET_W-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dmag_reg <= dneg ? DET_W'(-cof.det) : DET_W'(cof.det);
            for (int k = 0; k < 9; k++)
            begin
                cm_reg[k]  <= cof.adj[k][ADJ_W-1] ? -cof.adj[k] : cof.adj[k];
                neg_reg[k] <= cof.adj[k][ADJ_W-1] ^ dneg;
            end
            prep_side_reg.t    <= cof.t;
            prep_side_reg.zero <= (cof.det == '0);

            sb_reg[0] <= prep_side_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_v_reg <= 1'b0;
            sb_v_reg   <= '0;
        end
        else if (adv)
        begin
            prep_v_reg <= cof_valid;
            sb_v_reg   <= {sb_v_reg[DIV_LAT-2:0], prep_v_reg};
        end
    end

    for (genvar k = 0; k < 9; k++)
    begin : g_lane
        amxi_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk  (clk),
            .adv  (adv),
            .cm   (cm_reg[k]),
            .dmag (dmag_reg),
            .neg  (neg_reg[k]),
            .q    (q[k])
        );
    end

    assign lin.q    = q;
    assign lin.t    = sb_reg[DIV_LAT-1].t;
    assign lin.zero = sb_reg[DIV_LAT-1].zero;

    amxi_xlat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xlat (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sb_v_reg[DIV_LAT-1]),
        .lin       (lin),
        .out_valid (x_valid),
        .inv       (x_inv)
    );

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || inverse.ready)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= x_valid;
            end
        end
        else if (x_valid && adv)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || inverse.ready)
        begin
            out_reg <= skid_v_reg ? skid_reg : x_inv;
        end
        else if (adv)
        begin
            skid_reg <= x_inv;
        end
    end

    assign inverse.valid = out_v_reg;
    assign inverse.data  = out_reg;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry full while output register empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !inverse.ready && x_valid))
        else $error("skid entry filled without a stalled output");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg && inverse.ready |=> !skid_v_reg && out_v_reg)
        else $error("skid entry not drained on transfer");
`endif

endmodule
